/* hdl/clue_list_text_tokenizer_assert.svh */
// Assertion macros for the clue list text tokenizer.
`ifndef CLUE_LIST_TEXT_TOKENIZER_ASSERT_SVH
`define CLUE_LIST_TEXT_TOKENIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks that prop holds at every clock edge outside reset.
`define CLTT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that post holds in the cycle after pre, outside reset.
`define CLTT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define CLTT_ASSERT(label, clk, rst_n, prop, msg)
`define CLTT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

/* hdl/cltt_pkg.sv */
// Package with the transaction types and character codes of the clue list text tokenizer.
`default_nettype none

package cltt_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int PARAM_VALUE_W  = 16;
    localparam int PARAM_KIND_W   = 7;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_FILL   = 8'hFF;

    localparam logic [PARAM_KIND_W-1:0] KIND_DEFAULT = 7'h41;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } t_in;

    typedef struct packed {
        logic                     section;
        logic                     param_valid;
        logic [PARAM_VALUE_W-1:0] param_value;
        logic [PARAM_KIND_W-1:0]  param_kind;
        logic                     line_end;
    } t_out;

endpackage

`default_nettype wire

/* hdl/clue_list_text_tokenizer.sv */
// Top level of the clue list text tokenizer: input register, token logic and result register.
`default_nettype none

// The block takes one text byte (or an end-of-text marker) per transaction and can accept a new
// transaction every cycle while o_stall is low. Each transaction is held in an input register,
// decoded and folded into the token state by combinational logic, and its result, if any, is
// then placed in an output register, so a result passes through the input register and then
// the output register. The token value is accumulated with a multiply-by-ten add that saturates
// at 2^VALUE_BITS - 1; param_value carries its low 16 bits. Bytes that produce no result are
// consumed without occupying the output register.

`include "clue_list_text_tokenizer_assert.svh"

module clue_list_text_tokenizer #(
    parameter int VALUE_BITS = cltt_pkg::VALUE_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire cltt_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output cltt_pkg::t_out      o_data
);

    localparam int ACC_W = VALUE_BITS + 4;
    localparam logic [ACC_W-1:0] VALUE_MAX = {4'b0, {VALUE_BITS{1'b1}}};

    logic                  r_in_valid;
    cltt_pkg::t_in         r_in;
    logic                  r_out_valid;
    cltt_pkg::t_out        r_out;

    logic                  r_rows;
    logic                  r_comment;
    logic                  r_tok_started;
    logic [cltt_pkg::PARAM_KIND_W-1:0] r_tok_kind;
    logic [VALUE_BITS-1:0] r_tok_value;
    logic                  r_tok_has_digit;
    logic                  r_tok_bad;
    logic                  r_tok_term;
    logic                  r_line_has;

    logic                  n_rows;
    logic                  n_comment;
    logic                  n_tok_started;
    logic [cltt_pkg::PARAM_KIND_W-1:0] n_tok_kind;
    logic [VALUE_BITS-1:0] n_tok_value;
    logic                  n_tok_has_digit;
    logic                  n_tok_bad;
    logic                  n_tok_term;
    logic                  n_line_has;
    cltt_pkg::t_out        n_out;
    logic                  n_emit;

    logic                  process;
    logic                  in_accept;
    logic [7:0]            c;
    logic                  tok_ok;
    logic                  is_letter;
    logic                  is_digit;
    logic [ACC_W-1:0]      acc_ext;
    logic [ACC_W-1:0]      acc_sum;
    logic [VALUE_BITS+cltt_pkg::PARAM_VALUE_W-1:0] value_wide;

    assign process   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !process;
    assign in_accept = i_valid && !o_stall;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    assign c         = r_in.char_code;
    assign tok_ok    = r_tok_has_digit && !r_tok_bad;
    assign is_letter = ((c >= cltt_pkg::CH_UPPER_A) && (c <= cltt_pkg::CH_UPPER_Z)) ||
                       ((c >= cltt_pkg::CH_LOWER_A) && (c <= cltt_pkg::CH_LOWER_Z));
    assign is_digit  = (c >= cltt_pkg::CH_ZERO) && (c <= cltt_pkg::CH_NINE);
    assign acc_ext   = {4'b0, r_tok_value};
    assign acc_sum   = (acc_ext << 3) + (acc_ext << 1) + {{(ACC_W-4){1'b0}}, c[3:0]};
    assign value_wide = {{cltt_pkg::PARAM_VALUE_W{1'b0}}, r_tok_value};

    always_comb begin
        logic close_tok;
        logic close_ln;

        close_tok = 1'b0;
        close_ln  = 1'b0;

        n_rows          = r_rows;
        n_comment       = r_comment;
        n_tok_started   = r_tok_started;
        n_tok_kind      = r_tok_kind;
        n_tok_value     = r_tok_value;
        n_tok_has_digit = r_tok_has_digit;
        n_tok_bad       = r_tok_bad;
        n_tok_term      = r_tok_term;
        n_line_has      = r_line_has;

        if (r_in.action == cltt_pkg::ACT_END) begin
            close_ln  = 1'b1;
            n_rows    = 1'b0;
            n_comment = 1'b0;
        end else if ((c == cltt_pkg::CH_HASH) || (c == cltt_pkg::CH_PCT) ||
                     (c == cltt_pkg::CH_STAR)) begin
            close_ln  = 1'b1;
            n_comment = 1'b1;
        end else if ((c == cltt_pkg::CH_LF) || (c == cltt_pkg::CH_CR)) begin
            close_ln  = 1'b1;
            n_comment = 1'b0;
        end else if (!r_comment) begin
            if ((c == cltt_pkg::CH_SLASH) || (c == cltt_pkg::CH_PLUS) ||
                (c == cltt_pkg::CH_MINUS)) begin
                close_ln = 1'b1;
                n_rows   = 1'b1;
                if (c == cltt_pkg::CH_MINUS) begin
                    n_comment = 1'b1;
                end
            end else if ((c == cltt_pkg::CH_SPACE) || (c == cltt_pkg::CH_TAB) ||
                         (c == cltt_pkg::CH_DOT)) begin
                close_tok = 1'b1;
            end else if ((c != cltt_pkg::CH_FILL) && !r_tok_term) begin
                n_tok_started = 1'b1;
                if (c == cltt_pkg::CH_NUL) begin
                    n_tok_term = 1'b1;
                end else if (!r_tok_started && is_letter) begin
                    n_tok_kind = c[cltt_pkg::PARAM_KIND_W-1:0];
                end else if (is_digit) begin
                    n_tok_has_digit = 1'b1;
                    n_tok_value = (acc_sum > VALUE_MAX) ? {VALUE_BITS{1'b1}}
                                                        : acc_sum[VALUE_BITS-1:0];
                end else begin
                    n_tok_bad = 1'b1;
                end
            end
        end

        n_out.section     = r_rows;
        n_out.param_valid = 1'b0;
        n_out.param_value = '0;
        n_out.param_kind  = cltt_pkg::KIND_DEFAULT;
        n_out.line_end    = 1'b0;

        if (close_tok || close_ln) begin
            if (tok_ok) begin
                n_out.param_valid = 1'b1;
                n_out.param_value = value_wide[cltt_pkg::PARAM_VALUE_W-1:0];
                n_out.param_kind  = r_tok_kind;
            end
            n_tok_started   = 1'b0;
            n_tok_kind      = cltt_pkg::KIND_DEFAULT;
            n_tok_value     = '0;
            n_tok_has_digit = 1'b0;
            n_tok_bad       = 1'b0;
            n_tok_term      = 1'b0;
            if (close_ln) begin
                n_out.line_end = tok_ok || r_line_has;
                n_line_has     = 1'b0;
            end else begin
                n_line_has = r_line_has || tok_ok;
            end
        end

        n_emit = n_out.param_valid || n_out.line_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_rows          <= 1'b0;
            r_comment       <= 1'b0;
            r_tok_started   <= 1'b0;
            r_tok_kind      <= cltt_pkg::KIND_DEFAULT;
            r_tok_value     <= '0;
            r_tok_has_digit <= 1'b0;
            r_tok_bad       <= 1'b0;
            r_tok_term      <= 1'b0;
            r_line_has      <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end

            if (process && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (process) begin
                r_rows          <= n_rows;
                r_comment       <= n_comment;
                r_tok_started   <= n_tok_started;
                r_tok_kind      <= n_tok_kind;
                r_tok_value     <= n_tok_value;
                r_tok_has_digit <= n_tok_has_digit;
                r_tok_bad       <= n_tok_bad;
                r_tok_term      <= n_tok_term;
                r_line_has      <= n_line_has;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_data;
        end
        if (process && n_emit) begin
            r_out <= n_out;
        end
    end

    `CLTT_ASSERT(a_out_not_empty, i_clk, i_rst_n,
        !o_valid || o_data.param_valid || o_data.line_end,
        "Result transaction carries neither a clue nor a line end.")
    `CLTT_ASSERT(a_idle_fields, i_clk, i_rst_n,
        !o_valid || o_data.param_valid || ((o_data.param_value == '0) &&
        (o_data.param_kind == cltt_pkg::KIND_DEFAULT)),
        "Clue fields are not at their idle values without a clue.")
    `CLTT_ASSERT(a_empty_token, i_clk, i_rst_n,
        r_tok_started || ((r_tok_value == '0) && !r_tok_has_digit && !r_tok_bad && !r_tok_term),
        "Token state is set while no token is started.")
    `CLTT_ASSERT_NEXT(a_end_resets, i_clk, i_rst_n,
        process && (r_in.action == cltt_pkg::ACT_END),
        !r_rows && !r_comment && !r_line_has && !r_tok_started,
        "End of text did not return the tokenizer to its start state.")

endmodule

`default_nettype wire

/* dv/clue_list_text_tokenizer_tb.sv */
// Self-checking testbench for the clue list text tokenizer, driven by a directed table and random text.
`default_nettype none

module clue_list_text_tokenizer_tb;

    localparam int VBITS = cltt_pkg::VALUE_BITS_DEF;
    localparam logic [63:0] VALUE_MAX = (64'd1 << VBITS) - 64'd1;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS = 1200;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_GIVEN} t_exp_mode;

    typedef struct packed {
        logic           act;
        logic [7:0]     c;
        t_exp_mode      mode;
        cltt_pkg::t_out given;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    cltt_pkg::t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    cltt_pkg::t_out o_data;

    bit calm = 1'b0;
    int sent = 0;
    int mismatch_count = 0;
    cltt_pkg::t_out expected_results[$];

    logic        rows_sec = 1'b0;
    logic        in_cmt = 1'b0;
    logic        tok_started = 1'b0;
    logic [7:0]  tok_kind = cltt_pkg::CH_UPPER_A;
    logic [31:0] tok_value = '0;
    logic        tok_digit = 1'b0;
    logic        tok_bad = 1'b0;
    logic        tok_term = 1'b0;
    logic        line_has = 1'b0;

    t_dir_row directed_rows [DIRECTED_ROWS] = '{
        '{cltt_pkg::ACT_BYTE, "7",                  EXP_NONE,    '0},
        '{cltt_pkg::ACT_BYTE, cltt_pkg::CH_SPACE,   EXP_GIVEN,
          '{1'b0, 1'b1, 16'd7, cltt_pkg::KIND_DEFAULT, 1'b0}},
        '{cltt_pkg::ACT_BYTE, cltt_pkg::CH_LF,      EXP_GIVEN,
          '{1'b0, 1'b0, 16'd0, cltt_pkg::KIND_DEFAULT, 1'b1}},
        '{cltt_pkg::ACT_BYTE, "z",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "0",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "x",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, cltt_pkg::CH_DOT,     EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, 8'h80,                EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "5",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, cltt_pkg::CH_TAB,     EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "B",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "3",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, cltt_pkg::CH_NUL,     EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "9",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, cltt_pkg::CH_SPACE,   EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "9",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "9",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "9",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "9",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "9",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, cltt_pkg::CH_SLASH,   EXP_GIVEN,
          '{1'b0, 1'b1, 16'hFFFF, cltt_pkg::KIND_DEFAULT, 1'b1}},
        '{cltt_pkg::ACT_BYTE, cltt_pkg::CH_PLUS,    EXP_NONE,    '0},
        '{cltt_pkg::ACT_BYTE, cltt_pkg::CH_FILL,    EXP_PREDICT, '0},
        '{cltt_pkg::ACT_BYTE, "2",                  EXP_PREDICT, '0},
        '{cltt_pkg::ACT_END,  cltt_pkg::CH_FILL,    EXP_PREDICT, '0}
    };

    clue_list_text_tokenizer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit finish_token(inout cltt_pkg::t_out res);
        bit ok;
        ok = tok_digit && !tok_bad;
        if (ok) begin
            res.param_valid = 1'b1;
            res.param_value = tok_value[cltt_pkg::PARAM_VALUE_W-1:0];
            res.param_kind  = tok_kind[cltt_pkg::PARAM_KIND_W-1:0];
            line_has = 1'b1;
        end
        tok_started = 1'b0;
        tok_kind    = cltt_pkg::CH_UPPER_A;
        tok_value   = '0;
        tok_digit   = 1'b0;
        tok_bad     = 1'b0;
        tok_term    = 1'b0;
        return ok;
    endfunction

    function automatic bit finish_line(inout cltt_pkg::t_out res);
        bit any;
        any = finish_token(res);
        if (line_has) begin
            res.line_end = 1'b1;
            line_has = 1'b0;
            any = 1'b1;
        end
        return any;
    endfunction

    function automatic bit tokenize_byte(input cltt_pkg::t_in item,
                                         output cltt_pkg::t_out res);
        logic [7:0]  c;
        logic [63:0] acc;
        bit          produced;
        c = item.char_code;
        produced = 1'b0;
        res = '{section: rows_sec, param_valid: 1'b0, param_value: '0,
                param_kind: cltt_pkg::KIND_DEFAULT, line_end: 1'b0};
        if (item.action == cltt_pkg::ACT_END) begin
            produced = finish_line(res);
            rows_sec = 1'b0;
            in_cmt = 1'b0;
        end else if (c == cltt_pkg::CH_HASH || c == cltt_pkg::CH_PCT ||
                     c == cltt_pkg::CH_STAR) begin
            produced = finish_line(res);
            in_cmt = 1'b1;
        end else if (c == cltt_pkg::CH_LF || c == cltt_pkg::CH_CR) begin
            produced = finish_line(res);
            in_cmt = 1'b0;
        end else if (!in_cmt) begin
            if (c == cltt_pkg::CH_SLASH || c == cltt_pkg::CH_PLUS ||
                c == cltt_pkg::CH_MINUS) begin
                produced = finish_line(res);
                rows_sec = 1'b1;
                if (c == cltt_pkg::CH_MINUS) in_cmt = 1'b1;
            end else if (c == cltt_pkg::CH_SPACE || c == cltt_pkg::CH_TAB ||
                         c == cltt_pkg::CH_DOT) begin
                produced = finish_token(res);
            end else if (c != cltt_pkg::CH_FILL && !tok_term) begin
                if (c == cltt_pkg::CH_NUL) begin
                    tok_term = 1'b1;
                    tok_started = 1'b1;
                end else if (!tok_started &&
                             ((c >= cltt_pkg::CH_UPPER_A && c <= cltt_pkg::CH_UPPER_Z) ||
                              (c >= cltt_pkg::CH_LOWER_A && c <= cltt_pkg::CH_LOWER_Z))) begin
                    tok_kind = c;
                    tok_started = 1'b1;
                end else if (c >= cltt_pkg::CH_ZERO && c <= cltt_pkg::CH_NINE) begin
                    acc = 64'(tok_value) * 64'd10 + 64'(c - cltt_pkg::CH_ZERO);
                    if (acc > VALUE_MAX) acc = VALUE_MAX;
                    tok_value = acc[31:0];
                    tok_digit = 1'b1;
                    tok_started = 1'b1;
                end else begin
                    tok_bad = 1'b1;
                    tok_started = 1'b1;
                end
            end
        end
        return produced;
    endfunction

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1) == 0) return 8'(cltt_pkg::CH_UPPER_A + $urandom_range(25));
        return 8'(cltt_pkg::CH_LOWER_A + $urandom_range(25));
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'(cltt_pkg::CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] random_sep();
        case ($urandom_range(2))
            0: return cltt_pkg::CH_SPACE;
            1: return cltt_pkg::CH_TAB;
            default: return cltt_pkg::CH_DOT;
        endcase
    endfunction

    task automatic send_item(input logic act, input logic [7:0] c,
                             input t_exp_mode mode = EXP_PREDICT,
                             input cltt_pkg::t_out given = '0);
        cltt_pkg::t_in  item;
        cltt_pkg::t_out res;
        bit             produced;
        item.action = act;
        item.char_code = c;
        while (!calm && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= item;
        do @(posedge i_clk); while (o_stall);
        produced = tokenize_byte(item, res);
        if (mode == EXP_GIVEN) begin
            expected_results.insert(expected_results.size(), given);
        end else if (mode == EXP_PREDICT && produced) begin
            expected_results.insert(expected_results.size(), res);
        end
        sent++;
    endtask

    task automatic report_mismatch(input string what, input cltt_pkg::t_out exp,
                                   input cltt_pkg::t_out got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"Mismatch, %s: expected sec=%0d pv=%0d val=%0d kind=%0d le=%0d, ",
                      "got sec=%0d pv=%0d val=%0d kind=%0d le=%0d"},
                     what, exp.section, exp.param_valid, exp.param_value, exp.param_kind,
                     exp.line_end, got.section, got.param_valid, got.param_value,
                     got.param_kind, got.line_end);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= !calm && ($urandom_range(99) < 32);
    end

    always @(posedge i_clk) begin
        cltt_pkg::t_out exp;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", '0, o_data);
            end else begin
                exp = expected_results.pop_front();
                if (o_data.section !== exp.section || o_data.param_valid !== exp.param_valid ||
                    o_data.param_value !== exp.param_value ||
                    o_data.param_kind !== exp.param_kind || o_data.line_end !== exp.line_end)
                    report_mismatch("field differs", exp, o_data);
            end
        end
    end

    initial begin
        int pick;
        int ndig;
        int idx;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (idx = 0; idx < DIRECTED_ROWS; idx++)
            send_item(directed_rows[idx].act, directed_rows[idx].c, directed_rows[idx].mode,
                      directed_rows[idx].given);

        while (sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            calm = (sent >= 500 && sent < 750);
            pick = $urandom_range(99);
            if (pick < 55) begin
                if ($urandom_range(1) == 1) send_item(cltt_pkg::ACT_BYTE, random_letter());
                ndig = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(3, 1);
                repeat (ndig) send_item(cltt_pkg::ACT_BYTE, random_digit());
                send_item(cltt_pkg::ACT_BYTE, random_sep());
            end else if (pick < 68) begin
                send_item(cltt_pkg::ACT_BYTE,
                          ($urandom_range(1) == 0) ? cltt_pkg::CH_LF : cltt_pkg::CH_CR);
            end else if (pick < 76) begin
                case ($urandom_range(2))
                    0: send_item(cltt_pkg::ACT_BYTE, cltt_pkg::CH_SLASH);
                    1: send_item(cltt_pkg::ACT_BYTE, cltt_pkg::CH_PLUS);
                    default: send_item(cltt_pkg::ACT_BYTE, cltt_pkg::CH_MINUS);
                endcase
            end else if (pick < 82) begin
                case ($urandom_range(2))
                    0: send_item(cltt_pkg::ACT_BYTE, cltt_pkg::CH_HASH);
                    1: send_item(cltt_pkg::ACT_BYTE, cltt_pkg::CH_PCT);
                    default: send_item(cltt_pkg::ACT_BYTE, cltt_pkg::CH_STAR);
                endcase
                repeat ($urandom_range(4))
                    send_item(cltt_pkg::ACT_BYTE, 8'($urandom_range(255)));
                send_item(cltt_pkg::ACT_BYTE, cltt_pkg::CH_LF);
            end else if (pick < 86) begin
                send_item(cltt_pkg::ACT_END, 8'($urandom_range(255)));
            end else if (pick < 93) begin
                case ($urandom_range(3))
                    0: begin
                        send_item(cltt_pkg::ACT_BYTE, random_digit());
                        send_item(cltt_pkg::ACT_BYTE, random_letter());
                    end
                    1: begin
                        send_item(cltt_pkg::ACT_BYTE, random_digit());
                        send_item(cltt_pkg::ACT_BYTE, cltt_pkg::CH_NUL);
                        send_item(cltt_pkg::ACT_BYTE, 8'($urandom_range(255)));
                    end
                    2: send_item(cltt_pkg::ACT_BYTE, cltt_pkg::CH_NUL);
                    default: begin
                        send_item(cltt_pkg::ACT_BYTE, random_digit());
                        send_item(cltt_pkg::ACT_BYTE, 8'(8'h80 + $urandom_range(126)));
                    end
                endcase
                send_item(cltt_pkg::ACT_BYTE, random_sep());
            end else begin
                send_item(cltt_pkg::ACT_BYTE, 8'($urandom_range(255)));
            end
        end

        calm = 1'b0;
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
